FILE: rtl/ssid_prefix_oui_classifier_assert.svh
// assertion macros for the classifier checker
`ifndef SSID_PREFIX_OUI_CLASSIFIER_ASSERT_SVH
`define SSID_PREFIX_OUI_CLASSIFIER_ASSERT_SVH
// an implication from pre to post, checked outside reset
`define SPOC_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
// a condition that holds at every edge outside reset
`define SPOC_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

FILE: rtl/spoc_pkg.sv
// ----------------------------------------------------------------------------
// spoc_pkg
// prefix table, vendor OUI list and shared types of the classifier
// ----------------------------------------------------------------------------
package spoc_pkg;

   localparam int NUM_PAT = 41;
   localparam int MAX_LEN = 10;
   localparam int NUM_OUI = 5;
   localparam logic [5:0] NO_HIT = 6'd63;
   localparam logic [6:0] OUI_CONF = 7'd95;
   localparam logic [6:0] RES_CAP = 7'd64;
   localparam logic [0:0] CSR_RESULT_LIMIT = 1'b0;
   localparam logic [0:0] CSR_RECORD_LIMIT = 1'b1;
   localparam logic KIND_PREFIX = 1'b0;
   localparam logic KIND_OUI = 1'b1;

   typedef logic [8*MAX_LEN-1:0] text_type;

   typedef struct packed {
      text_type   text;
      logic [3:0] len;
      logic [6:0] conf;
      logic       cam;
   } prefix_type;

   typedef struct packed {
      logic        pat_hit;
      logic [5:0]  pat_idx;
      logic        oui_hit;
      logic        oui_emit;
      logic [5:0]  num0;
      logic        flag;
      logic        is_open;
      logic [7:0]  rssi;
      logic [47:0] bssid;
   } job_type;

   function automatic prefix_type pent(input string s, input int c, input int m);
      prefix_type e;
      int n;
      e = '0;
      n = s.len();
      for (int i = 0; i < MAX_LEN; i++) begin
         if (i < n) e.text[8*i +: 8] = s.getc(i);
      end
      e.len = 4'(n);
      e.conf = 7'(c);
      e.cam = 1'(m);
      return e;
   endfunction

   function automatic prefix_type prefix_at(input int p);
      case (p)
         0: return pent("MV", 85, 1);
         1: return pent(string'(40'h563338302D), 85, 1);
         2: return pent("YDXJ_", 85, 1);
         3: return pent("IPC-", 75, 1);
         4: return pent("IPCAM-", 75, 1);
         5: return pent("IP_CAM_", 80, 1);
         6: return pent("HDWIFICAM", 85, 1);
         7: return pent("CLOUDCAM", 80, 1);
         8: return pent("HIDVCAM", 90, 1);
         9: return pent("XM-", 80, 1);
         10: return pent("BVCAM-", 80, 1);
         11: return pent("P2PCAM-", 80, 1);
         12: return pent("TUTK-", 75, 1);
         13: return pent("JXLCAM", 85, 1);
         14: return pent("CARECAM-", 80, 1);
         15: return pent("ICAM-", 80, 1);
         16: return pent("AI_", 80, 1);
         17: return pent("WIFI-CAM", 75, 1);
         18: return pent("DEPSTECH_", 85, 1);
         19: return pent("HIK-", 85, 1);
         20: return pent(string'(80'h48494B564953494F4E5F), 85, 1);
         21: return pent("DH_", 80, 1);
         22: return pent("TAPO_", 80, 1);
         23: return pent("TAPO-", 80, 1);
         24: return pent(string'(64'h52454F4C494E4B5F), 80, 1);
         25: return pent(string'(40'h57595A455F), 80, 1);
         26: return pent(string'(64'h414D43524553545F), 80, 1);
         27: return pent(string'(40'h474F50524F), 90, 1);
         28: return pent(string'(64'h494E535441333630), 90, 1);
         29: return pent("OSMOACTION", 90, 1);
         30: return pent(string'(64'h424C41434B565545), 90, 1);
         31: return pent("VIOFO_", 85, 1);
         32: return pent("70MAI_", 85, 1);
         33: return pent("NEXTBASE", 85, 1);
         34: return pent("THINKWARE", 85, 1);
         35: return pent(string'(72'h41584F4E20424F4459), 90, 1);
         36: return pent("WGVISTA", 85, 1);
         37: return pent("PINEAPPLE", 90, 0);
         38: return pent("RING SETUP", 85, 1);
         39: return pent("BLINK-", 80, 1);
         40: return pent("FURBO_", 80, 1);
         default: return '0;
      endcase
   endfunction

   function automatic logic [23:0] oui_at(input int m);
      case (m)
         0: return 24'h78C4FA;
         1: return 24'h480560;
         2: return 24'h001DBA;
         3: return 24'h2C2617;
         4: return 24'hE0D55E;
         default: return 24'h0;
      endcase
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

endpackage

FILE: rtl/ssid_prefix_oui_classifier.sv
// path: a record's job enters the job queue with its final byte word;
// results are read from the queue head. throughput: one word per cycle while
// the job queue has room; a record with two results holds the result side for both words
// reset: synchronous, active high; limits return to 16 and 30, counts clear
// ----------------------------------------------------------------------------
// ssid_prefix_oui_classifier
// classifies access-point records by SSID prefix and vendor OUI
// ----------------------------------------------------------------------------
module ssid_prefix_oui_classifier import spoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_scan_start,
   input  logic [7:0]  req_ssid_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_ssid,
   input  logic [47:0] req_bssid,
   input  logic [7:0]  req_signal_level,
   input  logic        req_auth_open,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_pattern_index,
   output logic [6:0]  rsp_confidence_pct,
   output logic        rsp_camera_flag,
   output logic        rsp_is_open,
   output logic [7:0]  rsp_rssi_out,
   output logic [47:0] rsp_bssid_out,
   output logic [5:0]  rsp_match_number,
   output logic        rsp_oui_seen,
   output logic        rsp_last_result
);

   logic [6:0] rlim_ff;
   logic [7:0] klim_ff;
   logic fj_valid, fj_ready, q_valid, q_pop;
   job_type fj, qj;

   always_ff @(posedge clock) begin
      if (reset) begin
         rlim_ff <= 7'd16;
         klim_ff <= 8'd30;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RESULT_LIMIT: rlim_ff <= csr_data[6:0];
            CSR_RECORD_LIMIT: klim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   spoc_front u_front (
      .clock(clock), .reset(reset), .result_limit(rlim_ff), .record_limit(klim_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_scan_start(req_scan_start),
      .req_ssid_byte(req_ssid_byte), .req_last_byte(req_last_byte),
      .req_empty_ssid(req_empty_ssid), .req_bssid(req_bssid),
      .req_signal_level(req_signal_level), .req_auth_open(req_auth_open),
      .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
   );

   spoc_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(fj_valid), .in_job(fj),
      .in_ready(fj_ready), .out_valid(q_valid), .out_job(qj), .out_pop(q_pop)
   );

   spoc_back u_back (
      .clock(clock), .reset(reset), .job_valid(q_valid), .job(qj), .job_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_pattern_index(rsp_pattern_index),
      .rsp_confidence_pct(rsp_confidence_pct), .rsp_camera_flag(rsp_camera_flag),
      .rsp_is_open(rsp_is_open), .rsp_rssi_out(rsp_rssi_out),
      .rsp_bssid_out(rsp_bssid_out), .rsp_match_number(rsp_match_number),
      .rsp_oui_seen(rsp_oui_seen), .rsp_last_result(rsp_last_result)
   );

endmodule

FILE: rtl/spoc_front.sv
// ----------------------------------------------------------------------------
// spoc_front
// per-byte prefix tracking, record and scan counters, job issue
// ----------------------------------------------------------------------------
module spoc_front import spoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [6:0]  result_limit,
   input  logic [7:0]  record_limit,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_scan_start,
   input  logic [7:0]  req_ssid_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_ssid,
   input  logic [47:0] req_bssid,
   input  logic [7:0]  req_signal_level,
   input  logic        req_auth_open,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_ready
);

   logic [NUM_PAT-1:0] alive_ff, alive_in, alive_now;
   logic [5:0] pos_ff, pos_in;
   logic [7:0] rec_ff, rec_in;
   logic [6:0] tot_ff, tot_in;
   logic flag_ff, flag_in;
   logic [6:0] lim;
   logic [7:0] c;
   logic [6:0] cnt;
   logic go, fire, hit, ohit, oemit;
   logic [5:0] hidx;
   logic [6:0] tot_a;

   assign lim = (result_limit > RES_CAP) ? RES_CAP : result_limit;
   assign req_ready = job_ready;
   assign fire = req_valid && req_ready;
   assign go = rec_ff < record_limit && tot_ff < lim;
   assign c = fold(req_ssid_byte);
   assign cnt = {1'b0, pos_ff} + 7'd1;

   always_comb begin
      prefix_type e;
      alive_now = alive_ff;
      for (int p = 0; p < NUM_PAT; p++) begin
         e = prefix_at(p);
         if ({1'b0, pos_ff} < {3'b0, e.len}) begin
            if (fold(e.text[8*pos_ff[3:0] +: 8]) != c) alive_now[p] = 1'b0;
         end
      end
      hit = 1'b0;
      hidx = NO_HIT;
      for (int p = NUM_PAT - 1; p >= 0; p--) begin
         e = prefix_at(p);
         if (alive_now[p] && {3'b0, e.len} <= cnt) begin
            hit = 1'b1;
            hidx = 6'(p);
         end
      end
      ohit = 1'b0;
      for (int m = 0; m < NUM_OUI; m++) begin
         if (req_bssid[47:24] == oui_at(m)) ohit = 1'b1;
      end
   end

   assign tot_a = tot_ff + {6'b0, hit};
   assign oemit = ohit && tot_a < lim;

   always_comb begin
      alive_in = alive_ff;
      pos_in = pos_ff;
      rec_in = rec_ff;
      tot_in = tot_ff;
      flag_in = flag_ff;
      job_valid = 1'b0;
      if (fire) begin
         if (req_scan_start) begin
            alive_in = '1;
            pos_in = '0;
            rec_in = '0;
            tot_in = '0;
            flag_in = 1'b0;
         end else if (go) begin
            if (req_empty_ssid) begin
               alive_in = '1;
               pos_in = '0;
               rec_in = rec_ff + 8'd1;
            end else if (req_last_byte) begin
               alive_in = '1;
               pos_in = '0;
               rec_in = rec_ff + 8'd1;
               tot_in = tot_a + {6'b0, oemit};
               flag_in = flag_ff | ohit;
               job_valid = hit || oemit;
            end else begin
               alive_in = alive_now;
               pos_in = (pos_ff == 6'd63) ? pos_ff : pos_ff + 6'd1;
            end
         end
      end
   end

   assign job.pat_hit = hit;
   assign job.pat_idx = hidx;
   assign job.oui_hit = ohit;
   assign job.oui_emit = oemit;
   assign job.num0 = tot_ff[5:0];
   assign job.flag = flag_ff | ohit;
   assign job.is_open = req_auth_open;
   assign job.rssi = req_signal_level;
   assign job.bssid = req_bssid;

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '1;
         pos_ff <= '0;
         rec_ff <= '0;
         tot_ff <= '0;
         flag_ff <= 1'b0;
      end else begin
         alive_ff <= alive_in;
         pos_ff <= pos_in;
         rec_ff <= rec_in;
         tot_ff <= tot_in;
         flag_ff <= flag_in;
      end
   end

endmodule

FILE: rtl/spoc_queue.sv
// ----------------------------------------------------------------------------
// spoc_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module spoc_queue import spoc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   output logic    in_ready,
   output logic    out_valid,
   output job_type out_job,
   input  logic    out_pop
);

   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push;

   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (out_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, out_pop};
      end
   end

endmodule

FILE: rtl/spoc_back.sv
// ----------------------------------------------------------------------------
// spoc_back
// expands each job into one or two result words
// ----------------------------------------------------------------------------
module spoc_back import spoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_pattern_index,
   output logic [6:0]  rsp_confidence_pct,
   output logic        rsp_camera_flag,
   output logic        rsp_is_open,
   output logic [7:0]  rsp_rssi_out,
   output logic [47:0] rsp_bssid_out,
   output logic [5:0]  rsp_match_number,
   output logic        rsp_oui_seen,
   output logic        rsp_last_result
);

   logic second_ff, second_in;
   logic two, fire;
   prefix_type e;

   assign two = job.pat_hit && job.oui_emit;
   assign rsp_valid = job_valid;
   assign fire = rsp_valid && rsp_ready;
   assign job_pop = fire && (!two || second_ff);
   assign second_in = fire ? (two && !second_ff) : second_ff;
   assign e = prefix_at(int'(job.pat_idx));

   always_comb begin
      if (job.pat_hit && !second_ff) begin
         rsp_result_kind = KIND_PREFIX;
         rsp_pattern_index = job.pat_idx;
         rsp_confidence_pct = e.conf;
         rsp_camera_flag = e.cam;
         rsp_match_number = job.num0;
         rsp_last_result = !two;
      end else begin
         rsp_result_kind = KIND_OUI;
         rsp_pattern_index = '0;
         rsp_confidence_pct = OUI_CONF;
         rsp_camera_flag = 1'b1;
         rsp_match_number = job.num0 + {5'b0, job.pat_hit};
         rsp_last_result = 1'b1;
      end
   end

   assign rsp_is_open = job.is_open;
   assign rsp_rssi_out = job.rssi;
   assign rsp_bssid_out = job.bssid;
   assign rsp_oui_seen = job.flag;

   always_ff @(posedge clock) begin
      if (reset) second_ff <= 1'b0;
      else second_ff <= second_in;
   end

endmodule

FILE: rtl/spoc_checker.sv
// ----------------------------------------------------------------------------
// spoc_checker
// port-level checks of the classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "ssid_prefix_oui_classifier_assert.svh"
module spoc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [5:0]  rsp_pattern_index,
   input logic [6:0]  rsp_confidence_pct,
   input logic        rsp_oui_seen,
   input logic        rsp_last_result
);

   `SPOC_ASSERT_IMPL(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SPOC_ASSERT_NOW(a_oui_fields, clock, reset,
      !(rsp_valid && rsp_result_kind) ||
      (rsp_pattern_index == 6'd0 && rsp_confidence_pct == 7'd95 && rsp_oui_seen))
   `SPOC_ASSERT_NOW(a_idx, clock, reset, !rsp_valid || rsp_pattern_index < 6'd41)
   `SPOC_ASSERT_IMPL(a_pair, clock, reset, rsp_valid && rsp_ready && !rsp_last_result,
      rsp_valid && rsp_result_kind)

endmodule

bind ssid_prefix_oui_classifier spoc_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_kind(rsp_result_kind), .rsp_pattern_index(rsp_pattern_index),
   .rsp_confidence_pct(rsp_confidence_pct), .rsp_oui_seen(rsp_oui_seen),
   .rsp_last_result(rsp_last_result)
);
